### hw/rtl/brightest_3x3_window_locator_top_macros.svh
// Assertion helpers for the checker file.
`ifndef BRIGHTEST_3X3_WINDOW_LOCATOR_TOP_MACROS_SVH
`define BRIGHTEST_3X3_WINDOW_LOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define BW3L_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define BW3L_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bw3l_pkg.sv
// ----------------------------------------------------------------------------
// bw3l_pkg
// Types, constants and helpers of the brightest 3x3 window locator.
// ----------------------------------------------------------------------------
`default_nettype none

package bw3l_pkg;

    // Default frame limits
    localparam int MaxWidthDefault  = 1024;
    localparam int MaxHeightDefault = 1024;

    // Configuration port
    localparam int CfgDataWidth = 11;
    localparam int CfgIdxWidth  = 2;
    localparam logic [CfgDataWidth-1:0] FrameWidthReset  = 11'd512;
    localparam logic [CfgDataWidth-1:0] FrameHeightReset = 11'd424;
    localparam int DimMin = 3;

    // Sum widths: one pixel, three pixels of a row, full window
    localparam int PixSumWidth = 10;
    localparam int RowSumWidth = 12;
    localparam int WinSumWidth = 13;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic        found;
        logic [9:0]  peak_x;
        logic [9:0]  peak_y;
        logic [12:0] peak_sum;
    } peak_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    // Saturate a frame dimension to DimMin..hi
    function automatic int unsigned clamp_dim(input logic [CfgDataWidth-1:0] v,
                                              input int unsigned hi);
        int unsigned val;
        val = int'(v);
        if (val < DimMin) begin
            return DimMin;
        end
        if (val > hi) begin
            return hi;
        end
        return val;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/brightest_3x3_window_locator_top.sv
// ----------------------------------------------------------------------------
// brightest_3x3_window_locator_top: brightest nine-pixel window of a raster frame
// Throughput: one pixel per cycle while s_ready is high; s_ready is low after reset and in the cycle
//   after each config write, and the last pixel waits until the previous frame's divider is idle.
// Reset: synchronous, active low; clears counters, best window and handshakes, not the memory.
// ----------------------------------------------------------------------------
`default_nettype none

module brightest_3x3_window_locator_top #(
    parameter int MAX_WIDTH  = bw3l_pkg::MaxWidthDefault,
    parameter int MAX_HEIGHT = bw3l_pkg::MaxHeightDefault
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // pixel requests
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire bw3l_pkg::pixel_t                   s_data,
    // result requests
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output bw3l_pkg::peak_t                         m_data,
    // configuration writes
    input  wire logic                               cfg_we,
    input  wire logic [bw3l_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  wire logic [bw3l_pkg::CfgDataWidth-1:0]  cfg_data
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int TW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int DEPTH = 2 * MAX_WIDTH + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int DCW   = $clog2(PW);
    localparam int SW    = bw3l_pkg::PixSumWidth;
    localparam int RW    = bw3l_pkg::RowSumWidth;
    localparam int BW    = bw3l_pkg::WinSumWidth;

    // ------------------------------------------------------------------
    // Configuration: clamped dimensions and frame size
    // ------------------------------------------------------------------
    logic [WW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic [TW-1:0] total_reg;
    logic          cfg_wait_reg;
    logic [TW-1:0] w_ext;
    logic [TW-1:0] h_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg        <= WW'(bw3l_pkg::clamp_dim(bw3l_pkg::FrameWidthReset, MAX_WIDTH));
            h_reg        <= HW'(bw3l_pkg::clamp_dim(bw3l_pkg::FrameHeightReset, MAX_HEIGHT));
            cfg_wait_reg <= 1'b1;
        end else begin
            cfg_wait_reg <= cfg_we;
            if (cfg_we) begin
                unique case (cfg_index)
                    bw3l_pkg::REG_FRAME_WIDTH: begin
                        w_reg <= WW'(bw3l_pkg::clamp_dim(cfg_data, MAX_WIDTH));
                    end
                    bw3l_pkg::REG_FRAME_HEIGHT: begin
                        h_reg <= HW'(bw3l_pkg::clamp_dim(cfg_data, MAX_HEIGHT));
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // frame size is registered from the dimensions and follows them in the next cycle
    assign w_ext = TW'(w_reg);
    assign h_ext = TW'(h_reg);

    always_ff @(posedge aclk) begin
        total_reg <= w_ext * h_ext;
    end

    // ------------------------------------------------------------------
    // Input side: pixel counter, window eligibility, row sums
    // ------------------------------------------------------------------
    logic [PW-1:0]       pix_cnt_reg;
    logic [TW-1:0]       p_ext;
    logic                is_last;
    logic                win_ok;
    logic [PW-1:0]       centre_idx;
    logic                s_fire;
    logic                div_idle;
    logic [SW-1:0]       cur_sum;
    logic [SW-1:0]       prev1_reg;
    logic [SW-1:0]       prev2_reg;
    logic [RW-1:0]       row_sum;

    assign p_ext      = TW'(pix_cnt_reg);
    assign is_last    = (p_ext + TW'(1)) >= total_reg;
    assign win_ok     = (p_ext >= (TW'({w_reg, 1'b0}) + TW'(2))) && (p_ext < total_reg);
    assign centre_idx = PW'(p_ext - w_ext - TW'(1));

    assign s_ready = !cfg_wait_reg && (!is_last || div_idle);
    assign s_fire  = s_valid && s_ready;

    assign cur_sum = SW'(s_data.blue) + SW'(s_data.green) + SW'(s_data.red);
    assign row_sum = RW'(cur_sum) + RW'(prev1_reg) + RW'(prev2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_cnt_reg <= '0;
        end else if (s_fire) begin
            pix_cnt_reg <= is_last ? '0 : pix_cnt_reg + PW'(1);
        end
    end

    // last two pixel sums for the horizontal triple
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            prev2_reg <= prev1_reg;
            prev1_reg <= cur_sum;
        end
    end

    // ------------------------------------------------------------------
    // Row-sum memory: circular, one write and two reads per pixel
    // ------------------------------------------------------------------
    logic [RW-1:0]  row_mem [DEPTH];
    logic [AW-1:0]  wptr_reg;
    logic [AW:0]    wp_ext;
    logic [AW:0]    dist1;
    logic [AW:0]    dist2;
    logic [AW:0]    addr1_full;
    logic [AW:0]    addr2_full;
    logic [AW-1:0]  rd_addr1;
    logic [AW-1:0]  rd_addr2;
    logic [RW-1:0]  rd1_reg;
    logic [RW-1:0]  rd2_reg;

    assign wp_ext = (AW+1)'(wptr_reg);
    assign dist1  = (AW+1)'(w_reg);
    assign dist2  = (AW+1)'({w_reg, 1'b0});

    // one row and two rows back, modulo the depth
    assign addr1_full = (wp_ext >= dist1) ? (wp_ext - dist1)
                                          : (wp_ext + (AW+1)'(DEPTH) - dist1);
    assign addr2_full = (wp_ext >= dist2) ? (wp_ext - dist2)
                                          : (wp_ext + (AW+1)'(DEPTH) - dist2);
    assign rd_addr1   = addr1_full[AW-1:0];
    assign rd_addr2   = addr2_full[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
        end else if (s_fire) begin
            wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
        end
    end

    // read distances are at least three entries, so never the write entry
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            row_mem[wptr_reg] <= row_sum;
            rd1_reg           <= row_mem[rd_addr1];
            rd2_reg           <= row_mem[rd_addr2];
        end
    end

    // ------------------------------------------------------------------
    // Window stage: full sum and running maximum
    // ------------------------------------------------------------------
    logic          st1_valid_reg;
    logic          st1_ok_reg;
    logic          st1_last_reg;
    logic [RW-1:0] st1_row_reg;
    logic [PW-1:0] st1_c_reg;
    logic [WW-1:0] st1_w_reg;
    logic [BW-1:0] win_sum;
    logic          better;
    logic          handoff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_ok_reg   <= win_ok;
            st1_last_reg <= is_last;
            st1_row_reg  <= row_sum;
            st1_c_reg    <= centre_idx;
            st1_w_reg    <= w_reg;
        end
    end

    assign win_sum = BW'(st1_row_reg) + BW'(rd1_reg) + BW'(rd2_reg);

    logic [BW-1:0] best_sum_reg;
    logic [PW-1:0] best_c_reg;
    logic [WW-1:0] best_w_reg;
    logic          best_valid_reg;

    // strict compare keeps the first of equal sums
    assign better  = st1_valid_reg && st1_ok_reg && (win_sum > best_sum_reg);
    assign handoff = st1_valid_reg && st1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || handoff) begin
            best_sum_reg   <= '0;
            best_c_reg     <= '0;
            best_w_reg     <= '0;
            best_valid_reg <= 1'b0;
        end else if (better) begin
            best_sum_reg   <= win_sum;
            best_c_reg     <= st1_c_reg;
            best_w_reg     <= st1_w_reg;
            best_valid_reg <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Coordinate divider: index / width, one quotient bit per cycle
    // ------------------------------------------------------------------
    bw3l_pkg::div_state_t div_state_reg;
    bw3l_pkg::div_state_t div_state_next;
    logic            div_load;
    logic            div_step;
    logic            out_load;
    logic            out_free;
    logic [PW-1:0]   div_q_reg;
    logic [WW-1:0]   div_r_reg;
    logic [WW-1:0]   div_d_reg;
    logic [DCW-1:0]  div_cnt_reg;
    logic            div_found_reg;
    logic [BW-1:0]   div_sum_reg;
    logic [WW:0]     trial;
    logic [WW:0]     trial_diff;
    logic            trial_ge;
    logic            m_valid_reg;
    bw3l_pkg::peak_t m_data_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign div_idle = (div_state_reg == bw3l_pkg::DIV_IDLE);

    // next state
    always_comb begin
        div_state_next = div_state_reg;
        unique case (div_state_reg)
            bw3l_pkg::DIV_IDLE: begin
                if (handoff) begin
                    div_state_next = bw3l_pkg::DIV_RUN;
                end
            end
            bw3l_pkg::DIV_RUN: begin
                if (div_cnt_reg == DCW'(PW - 1)) begin
                    div_state_next = bw3l_pkg::DIV_DONE;
                end
            end
            bw3l_pkg::DIV_DONE: begin
                if (out_free) begin
                    div_state_next = bw3l_pkg::DIV_IDLE;
                end
            end
            default: begin
                div_state_next = bw3l_pkg::DIV_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        div_load = 1'b0;
        div_step = 1'b0;
        out_load = 1'b0;
        unique case (div_state_reg)
            bw3l_pkg::DIV_IDLE: begin
                div_load = handoff;
            end
            bw3l_pkg::DIV_RUN: begin
                div_step = 1'b1;
            end
            bw3l_pkg::DIV_DONE: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_state_reg <= bw3l_pkg::DIV_IDLE;
        end else begin
            div_state_reg <= div_state_next;
        end
    end

    // restoring division step
    assign trial      = {div_r_reg, div_q_reg[PW-1]};
    assign trial_ge   = trial >= (WW+1)'(div_d_reg);
    assign trial_diff = trial - (WW+1)'(div_d_reg);

    always_ff @(posedge aclk) begin
        if (div_load) begin
            div_q_reg     <= better ? st1_c_reg : best_c_reg;
            div_d_reg     <= better ? st1_w_reg : best_w_reg;
            div_sum_reg   <= better ? win_sum : best_sum_reg;
            div_found_reg <= better || best_valid_reg;
            div_r_reg     <= '0;
            div_cnt_reg   <= '0;
        end else if (div_step) begin
            div_q_reg   <= {div_q_reg[PW-2:0], trial_ge};
            div_r_reg   <= trial_ge ? trial_diff[WW-1:0] : trial[WW-1:0];
            div_cnt_reg <= div_cnt_reg + DCW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // a dark frame reports all zeros
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.found    <= div_found_reg;
            m_data_reg.peak_x   <= div_found_reg ? 10'(div_r_reg) : '0;
            m_data_reg.peak_y   <= div_found_reg ? 10'(div_q_reg) : '0;
            m_data_reg.peak_sum <= div_sum_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

### hw/rtl/bw3l_checker.sv
// ----------------------------------------------------------------------------
// bw3l_checker
// Port-level checks of the brightest 3x3 window locator, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "brightest_3x3_window_locator_top_macros.svh"

module bw3l_checker (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_valid,
    input wire logic            s_ready,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire bw3l_pkg::peak_t m_data,
    input wire logic            cfg_we
);

    logic m_stall;
    logic res_dark;
    logic res_lit;
    logic zero_fields;

    assign m_stall     = m_valid && !m_ready;
    assign res_dark    = m_valid && !m_data.found;
    assign res_lit     = m_valid && m_data.found;
    assign zero_fields = (m_data.peak_x == '0) && (m_data.peak_y == '0)
                         && (m_data.peak_sum == '0);

    // stalled result request holds
    `BW3L_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_stall, m_valid && $stable(m_data), "result changed while stalled")

    // dark frame reports zeros
    `BW3L_ASSERT_NOW(a_dark_zero, aclk, aresetn, res_dark, zero_fields, "dark result not zero")

    // a found window has a nonzero sum
    `BW3L_ASSERT_NOW(a_lit_sum, aclk, aresetn, res_lit, m_data.peak_sum != '0, "found with zero sum")

    // no pixel is taken in the cycle after a config write, while the frame size settles
    `BW3L_ASSERT_NEXT(a_cfg_settle, aclk, aresetn, cfg_we, !s_ready, "pixel taken after config write")

endmodule

bind brightest_3x3_window_locator_top bw3l_checker u_bw3l_checker (.*);

`default_nettype wire
